// ----- hdl/assert_macros.svh -----
// ---------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the semaphore table RTL.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ASSERT_IMPLIES(name, clk, rstn, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define ASSERT_NEXT(name, clk, rstn, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) else $error(msg);

`endif

// ----- hdl/csem_pkg.sv -----
// ---------------------------------------------------------------------------
// csem_pkg
// Shared codes, widths and types of the counting semaphore table.
// ---------------------------------------------------------------------------
package csem_pkg;

  localparam int NUM_SEMAPHORES_DEF = 256;
  localparam int COUNT_WIDTH_DEF    = 16;

  localparam int OP_W     = 3;
  localparam int SEM_ID_W = 8;
  localparam int INIT_W   = 16;
  localparam int STATUS_W = 3;
  localparam int OUT_CNT_W = 16;
  localparam int IN_DATA_W  = 32;
  localparam int OUT_DATA_W = 32;

  // free-entry search works on groups of this many flags
  localparam int GROUP_SIZE = 16;
  localparam int GROUP_IDX_W = 4;

  localparam logic [OP_W-1:0] OP_ALLOC = 3'd0;
  localparam logic [OP_W-1:0] OP_OPEN  = 3'd1;
  localparam logic [OP_W-1:0] OP_CLOSE = 3'd2;
  localparam logic [OP_W-1:0] OP_UP    = 3'd3;
  localparam logic [OP_W-1:0] OP_DOWN  = 3'd4;

  localparam logic [STATUS_W-1:0] ST_OK           = 3'd0;
  localparam logic [STATUS_W-1:0] ST_BAD_ID       = 3'd1;
  localparam logic [STATUS_W-1:0] ST_ALREADY_OPEN = 3'd2;
  localparam logic [STATUS_W-1:0] ST_CLOSED       = 3'd3;
  localparam logic [STATUS_W-1:0] ST_WOULD_BLOCK  = 3'd4;
  localparam logic [STATUS_W-1:0] ST_NONE_FREE    = 3'd5;
  localparam logic [STATUS_W-1:0] ST_OVERFLOW     = 3'd6;

  // result of the lowest-free-entry search
  typedef struct packed {
    logic                found;
    logic [SEM_ID_W-1:0] idx;
  } find_res_t;

endpackage

// ----- hdl/counting_semaphore_table_unit.sv -----
// ---------------------------------------------------------------------------
// counting_semaphore_table_unit
// Bank of counting semaphores: allocate, open, close, up and down requests
// on a table of open flags and counts, one result per request.
// ---------------------------------------------------------------------------
//
//  Channel  Dir  Ports                    Content
//  in_      in   in_tvalid/tready/tdata   operation, sem_id, init_value
//  out_     out  out_tvalid/tready/tdata  status, alloc_id, wake, count
//
//  Steps: at acceptance the count memory is read and the first level of the
//  free-entry search is registered; in execute the group is selected, the
//  entry modified and written back, and the result loaded. One request is in
//  flight at a time. Stalls: a held result does not block acceptance; the next
//  request waits in execute until it drains.
//  Reset: rst_n closes every entry at once; counts need no clearing.
//
`include "assert_macros.svh"

module counting_semaphore_table_unit #(
  parameter int NUM_SEMAPHORES = csem_pkg::NUM_SEMAPHORES_DEF,
  parameter int COUNT_WIDTH    = csem_pkg::COUNT_WIDTH_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_tvalid,
  output logic                            in_tready,
  // [2:0] operation, [10:3] sem_id, [26:11] init_value, [31:27] zero
  input  logic [csem_pkg::IN_DATA_W-1:0]  in_tdata,
  output logic                            out_tvalid,
  input  logic                            out_tready,
  // [2:0] status, [10:3] alloc_id, [11] wake, [27:12] count, [31:28] zero
  output logic [csem_pkg::OUT_DATA_W-1:0] out_tdata
);
  import csem_pkg::*;

  // only ids reachable through the 8-bit sem_id are kept
  localparam int ADDR_LIMIT = (NUM_SEMAPHORES < 256) ? NUM_SEMAPHORES : 256;
  localparam int IDX_W      = (ADDR_LIMIT > 1) ? $clog2(ADDR_LIMIT) : 1;
  localparam logic [COUNT_WIDTH-1:0] CNT_MAX = {COUNT_WIDTH{1'b1}};

  localparam logic S_IDLE = 1'b0;
  localparam logic S_EXEC = 1'b1;

  logic                   state_r, state_nxt;
  logic [OP_W-1:0]        op_r;
  logic [SEM_ID_W-1:0]    id_r;
  logic [COUNT_WIDTH-1:0] init_r, init_clamp;
  logic [ADDR_LIMIT-1:0]  flags_r, flags_nxt;
  logic                   out_valid_r, out_valid_nxt;
  logic [OUT_DATA_W-1:0]  out_data_r;

  logic [OP_W-1:0]        in_op;
  logic [SEM_ID_W-1:0]    in_id;
  logic [INIT_W-1:0]      in_init;
  logic                   in_fire;
  logic                   exec_done;

  logic [IDX_W-1:0]       rd_addr, wr_addr, id_idx, find_idx;
  logic                   wr_en;
  logic [COUNT_WIDTH-1:0] wr_data, rd_count;
  find_res_t              find;

  logic                   id_ok, id_open;
  logic                   set_flag, clr_flag;
  logic [STATUS_W-1:0]    res_status;
  logic [SEM_ID_W-1:0]    res_alloc;
  logic                   res_wake;
  logic [COUNT_WIDTH-1:0] res_count;
  logic [32:0]            res_count_ext;

  assign in_op   = in_tdata[2:0];
  assign in_id   = in_tdata[10:3];
  assign in_init = in_tdata[26:11];

  assign in_tready = (state_r == S_IDLE);
  assign in_fire   = in_tvalid && in_tready;
  // complete once the output register is free to take the result
  assign exec_done = (state_r == S_EXEC) && (!out_valid_r || out_tready);

  // clip initial values above the largest count
  assign init_clamp = (33'(in_init) > 33'(CNT_MAX)) ? CNT_MAX : COUNT_WIDTH'(in_init);

  assign id_idx   = id_r[IDX_W-1:0];
  assign find_idx = find.idx[IDX_W-1:0];
  // hold the read address on the stored id while the request waits
  assign rd_addr  = (state_r == S_IDLE) ? in_id[IDX_W-1:0] : id_idx;

  csem_ram #(
    .WIDTH (COUNT_WIDTH),
    .DEPTH (ADDR_LIMIT),
    .AW    (IDX_W)
  ) u_counts (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_addr (rd_addr),
    .rd_data (rd_count)
  );

  csem_free_find #(
    .ADDR_LIMIT (ADDR_LIMIT)
  ) u_find (
    .clk   (clk),
    .load  (in_fire),
    .flags (flags_r),
    .res   (find)
  );

  assign id_ok   = ({1'b0, id_r} < 9'(ADDR_LIMIT));
  assign id_open = flags_r[id_idx];

  // decide the result and the table update of the request in execute
  always_comb begin
    res_status = ST_OK;
    res_alloc  = '0;
    res_wake   = 1'b0;
    res_count  = '0;
    wr_en      = 1'b0;
    wr_addr    = id_idx;
    wr_data    = init_r;
    set_flag   = 1'b0;
    clr_flag   = 1'b0;
    if (op_r == OP_ALLOC) begin
      if (find.found) begin
        res_alloc = find.idx;
        res_count = init_r;
        wr_en     = 1'b1;
        wr_addr   = find_idx;
        set_flag  = 1'b1;
      end else begin
        res_status = ST_NONE_FREE;
      end
    end else if (!id_ok) begin
      res_status = ST_BAD_ID;
    end else begin
      case (op_r)
        OP_OPEN: begin
          if (id_open) begin
            res_status = ST_ALREADY_OPEN;
          end else begin
            res_count = init_r;
            wr_en     = 1'b1;
            set_flag  = 1'b1;
          end
        end
        OP_CLOSE: begin
          clr_flag = 1'b1;
        end
        OP_UP: begin
          if (!id_open) begin
            res_status = ST_CLOSED;
          end else if (rd_count == CNT_MAX) begin
            res_status = ST_OVERFLOW;
            res_count  = CNT_MAX;
          end else begin
            res_wake  = (rd_count == '0);
            res_count = rd_count + COUNT_WIDTH'(1);
            wr_en     = 1'b1;
            wr_data   = res_count;
          end
        end
        OP_DOWN: begin
          if (!id_open) begin
            res_status = ST_CLOSED;
          end else if (rd_count == '0) begin
            res_status = ST_WOULD_BLOCK;
          end else begin
            res_count = rd_count - COUNT_WIDTH'(1);
            wr_en     = 1'b1;
            wr_data   = res_count;
          end
        end
        default: begin
          res_status = ST_BAD_ID;
        end
      endcase
    end
    // commit only when the result is taken into the output register
    if (!exec_done) begin
      wr_en    = 1'b0;
      set_flag = 1'b0;
      clr_flag = 1'b0;
    end
  end

  assign res_count_ext = 33'(res_count);

  always_comb begin
    flags_nxt = flags_r;
    if (set_flag) begin
      flags_nxt[wr_addr] = 1'b1;
    end
    if (clr_flag) begin
      flags_nxt[id_idx] = 1'b0;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        if (exec_done) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // drop the output once taken, load it when a request completes
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
    if (exec_done) begin
      out_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      flags_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      flags_r     <= flags_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      op_r   <= in_op;
      id_r   <= in_id;
      init_r <= init_clamp;
    end
    if (exec_done) begin
      out_data_r <= {4'd0, res_count_ext[OUT_CNT_W-1:0], res_wake, res_alloc, res_status};
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  // the entry picked by allocate must still be closed
  `ASSERT_IMPLIES(a_alloc_pick_free, clk, rst_n, (state_r == S_EXEC) && (op_r == OP_ALLOC) && find.found, !flags_r[find_idx], "allocate picked an open entry")
  // an accepted request goes to execute in the next cycle
  `ASSERT_NEXT(a_fire_to_exec, clk, rst_n, in_fire, (state_r == S_EXEC), "accepted request did not enter execute")
  // a completed request leaves a result and returns to idle
  `ASSERT_NEXT(a_done_result, clk, rst_n, exec_done, out_tvalid && (state_r == S_IDLE), "completed request left no result")
  // an opened entry reads as open after its write-back
  `ASSERT_NEXT(a_open_sticks, clk, rst_n, set_flag, flags_r[$past(wr_addr)], "opened entry not marked open")

endmodule

// ----- hdl/csem_ram.sv -----
// ---------------------------------------------------------------------------
// csem_ram
// Generic single-write, single-read RAM with a registered read port.
// ---------------------------------------------------------------------------
module csem_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 256,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    rd_data_r <= mem_r[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

// ----- hdl/csem_free_find.sv -----
// ---------------------------------------------------------------------------
// csem_free_find
// Two-level search for the lowest closed entry: per-group results are
// registered on load, the group select follows in the next cycle.
// ---------------------------------------------------------------------------
module csem_free_find #(
  parameter int ADDR_LIMIT = 256
) (
  input  logic                   clk,
  input  logic                   load,
  input  logic [ADDR_LIMIT-1:0]  flags,
  output csem_pkg::find_res_t    res
);
  import csem_pkg::*;

  localparam int NUM_GROUPS = (ADDR_LIMIT + GROUP_SIZE - 1) / GROUP_SIZE;
  localparam int PAD_W      = NUM_GROUPS * GROUP_SIZE;

  logic [PAD_W-1:0]       flags_pad;
  logic [NUM_GROUPS-1:0]  grp_any_nxt;
  logic [NUM_GROUPS-1:0]  grp_any_r;
  logic [GROUP_IDX_W-1:0] grp_lo_nxt [NUM_GROUPS];
  logic [GROUP_IDX_W-1:0] grp_lo_r   [NUM_GROUPS];

  // entries past the limit count as open so they are never picked
  always_comb begin
    flags_pad = '1;
    flags_pad[ADDR_LIMIT-1:0] = flags;
  end

  always_comb begin
    for (int g = 0; g < NUM_GROUPS; g++) begin
      grp_any_nxt[g] = 1'b0;
      grp_lo_nxt[g]  = '0;
      for (int b = GROUP_SIZE - 1; b >= 0; b--) begin
        if (!flags_pad[g*GROUP_SIZE + b]) begin
          grp_any_nxt[g] = 1'b1;
          grp_lo_nxt[g]  = GROUP_IDX_W'(b);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      grp_any_r <= grp_any_nxt;
      for (int g = 0; g < NUM_GROUPS; g++) begin
        grp_lo_r[g] <= grp_lo_nxt[g];
      end
    end
  end

  always_comb begin
    res = '0;
    for (int g = NUM_GROUPS - 1; g >= 0; g--) begin
      if (grp_any_r[g]) begin
        res.found = 1'b1;
        res.idx   = SEM_ID_W'((g * GROUP_SIZE) + int'(grp_lo_r[g]));
      end
    end
  end

endmodule

// ----- tb/counting_semaphore_table_unit_tb.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// counting_semaphore_table_unit_tb
// Self-checking bench for the counting semaphore table. Requests go in on
// the input stream. A behavioural copy of the table predicts each result at
// acceptance, and every result taken from the output stream is compared
// field by field with the oldest prediction still waiting.
// ---------------------------------------------------------------------------
module counting_semaphore_table_unit_tb;
  import csem_pkg::*;

  localparam int ADDR_LIMIT = (NUM_SEMAPHORES_DEF < 256) ? NUM_SEMAPHORES_DEF : 256;
  localparam logic [COUNT_WIDTH_DEF-1:0] COUNT_MAX = '1;

  // one result as the block reports it
  typedef struct packed {
    logic [STATUS_W-1:0]  status;
    logic [SEM_ID_W-1:0]  alloc_id;
    logic                 wake;
    logic [OUT_CNT_W-1:0] count;
  } sem_result_t;

  logic                  clk        = 1'b0;
  logic                  rst_n      = 1'b0;
  logic                  in_tvalid  = 1'b0;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata   = '0;
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [OUT_DATA_W-1:0] out_tdata;

  // shadow copy of the table, advanced once per accepted request
  bit                         entry_open [ADDR_LIMIT];
  logic [COUNT_WIDTH_DEF-1:0] sem_count  [ADDR_LIMIT];

  sem_result_t expected_results[$];
  int          mismatches    = 0;
  int          send_idle_pct = 0;
  int          recv_idle_pct = 0;

  // long receiver hold-off, started by toggling hold_go
  bit hold_go   = 1'b0;
  bit hold_seen = 1'b0;
  int hold_len  = 0;
  int hold_left = 0;

  always #2 clk = ~clk;

  counting_semaphore_table_unit i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  // Work out the result of one request and update the shadow table.
  function automatic sem_result_t predict_request(input logic [OP_W-1:0] op,
                                                  input logic [SEM_ID_W-1:0] id,
                                                  input logic [INIT_W-1:0] init);
    sem_result_t                r;
    logic [COUNT_WIDTH_DEF-1:0] start;
    bit                         found;
    r     = '0;
    found = 1'b0;
    // clamp an oversized start value to the largest count
    start = (init > COUNT_MAX) ? COUNT_MAX : init[COUNT_WIDTH_DEF-1:0];
    if (op == OP_ALLOC) begin
      r.status = ST_NONE_FREE;
      for (int i = 0; i < ADDR_LIMIT; i++) begin
        if (!found && !entry_open[i]) begin
          found         = 1'b1;
          entry_open[i] = 1'b1;
          sem_count[i]  = start;
          r.status      = ST_OK;
          r.alloc_id    = i[SEM_ID_W-1:0];
          r.count       = start;
        end
      end
    end else if (op > OP_DOWN || int'(id) >= ADDR_LIMIT) begin
      r.status = ST_BAD_ID;
    end else begin
      case (op)
        OP_OPEN: begin
          if (entry_open[id]) begin
            r.status = ST_ALREADY_OPEN;
          end else begin
            entry_open[id] = 1'b1;
            sem_count[id]  = start;
            r.count        = start;
          end
        end
        OP_CLOSE: begin
          entry_open[id] = 1'b0;
        end
        OP_UP: begin
          if (!entry_open[id]) begin
            r.status = ST_CLOSED;
          end else if (sem_count[id] == COUNT_MAX) begin
            r.status = ST_OVERFLOW;
            r.count  = COUNT_MAX;
          end else begin
            r.wake        = (sem_count[id] == '0);
            sem_count[id] = sem_count[id] + COUNT_WIDTH_DEF'(1);
            r.count       = sem_count[id];
          end
        end
        default: begin
          if (!entry_open[id]) begin
            r.status = ST_CLOSED;
          end else if (sem_count[id] == '0) begin
            r.status = ST_WOULD_BLOCK;
          end else begin
            sem_count[id] = sem_count[id] - COUNT_WIDTH_DEF'(1);
            r.count       = sem_count[id];
          end
        end
      endcase
    end
    return r;
  endfunction

  // Pick an open entry, starting the scan at a random place; fall back to a
  // random index when the whole table is closed.
  function automatic logic [SEM_ID_W-1:0] pick_open_id();
    int start;
    int idx;
    start = $urandom_range(ADDR_LIMIT - 1);
    for (int k = 0; k < ADDR_LIMIT; k++) begin
      idx = (start + k) % ADDR_LIMIT;
      if (entry_open[idx]) return idx[SEM_ID_W-1:0];
    end
    return start[SEM_ID_W-1:0];
  endfunction

  // Start values biased towards the edges of the count range.
  function automatic logic [INIT_W-1:0] pick_init();
    case ($urandom_range(9))
      0:       return '0;
      1:       return INIT_W'(1);
      2:       return '1;
      3:       return {{(INIT_W-1){1'b1}}, 1'b0};
      default: return INIT_W'($urandom_range(65535));
    endcase
  endfunction

  // Offer one request, hold it until accepted, then log its prediction.
  task automatic send_request(input logic [OP_W-1:0] op, input logic [SEM_ID_W-1:0] id,
                              input logic [INIT_W-1:0] init);
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {{(IN_DATA_W-OP_W-SEM_ID_W-INIT_W){1'b0}}, init, id, op};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    expected_results.push_back(predict_request(op, id, init));
  endtask

  // Extremes of every field and each corner of the semaphore behaviour.
  task automatic test_directed_cases();
    send_request(OP_UP,    8'd0,   16'h1234);  // up on a closed entry
    send_request(OP_DOWN,  8'd255, 16'hFFFF);  // down on a closed entry
    send_request(OP_ALLOC, 8'd77,  16'h0000);  // lowest free is entry 0
    send_request(OP_DOWN,  8'd0,   16'h0000);  // down at zero would block
    send_request(OP_UP,    8'd0,   16'h0000);  // up from zero wakes
    send_request(OP_UP,    8'd0,   16'h0000);
    send_request(OP_DOWN,  8'd0,   16'h0000);
    send_request(OP_OPEN,  8'd255, 16'hFFFF);  // open at the largest count
    send_request(OP_OPEN,  8'd255, 16'h0001);  // already open
    send_request(OP_UP,    8'd255, 16'h0000);  // saturate with overflow
    send_request(OP_DOWN,  8'd255, 16'h0000);
    send_request(OP_CLOSE, 8'd0,   16'h0000);
    send_request(OP_CLOSE, 8'd0,   16'hFFFF);  // close an already closed entry
    send_request(OP_ALLOC, 8'd0,   16'hABCD);
    send_request(OP_ALLOC, 8'd255, 16'h5432);
    send_request(3'd5,     8'd1,   16'hFFFF);  // unknown operation codes
    send_request(3'd6,     8'd170, 16'h5555);
    send_request(3'd7,     8'd85,  16'hAAAA);
    send_request(OP_OPEN,  8'd128, 16'h8000);
    send_request(OP_UP,    8'd128, 16'h7FFF);
    send_request(OP_OPEN,  8'd254, 16'hFFFE);
    send_request(OP_UP,    8'd254, 16'h0000);  // reaches the largest count
    send_request(OP_UP,    8'd254, 16'h0000);  // then overflows
  endtask

  // Fill the whole table, run out of entries, then free a few and refill.
  task automatic test_table_exhaustion();
    for (int i = 0; i < ADDR_LIMIT; i++) begin
      send_request(OP_CLOSE, i[SEM_ID_W-1:0], INIT_W'($urandom_range(65535)));
    end
    for (int i = 0; i <= ADDR_LIMIT; i++) begin
      send_request(OP_ALLOC, SEM_ID_W'($urandom_range(255)), pick_init());
    end
    repeat (8) send_request(OP_CLOSE, SEM_ID_W'($urandom_range(ADDR_LIMIT - 1)), '0);
    repeat (9) send_request(OP_ALLOC, SEM_ID_W'($urandom_range(255)), pick_init());
  endtask

  // Hold the receiver off for a long stretch while requests keep coming,
  // so the block backs up and drops in_tready.
  task automatic test_output_backpressure();
    hold_len <= 300;
    hold_go  <= ~hold_go;
    @(posedge clk);
    repeat (40) begin
      if ($urandom_range(1))
        send_request(OP_UP, pick_open_id(), INIT_W'($urandom_range(65535)));
      else
        send_request(OP_DOWN, pick_open_id(), INIT_W'($urandom_range(65535)));
    end
  endtask

  // Mostly well-formed traffic on open entries, with a share of requests on
  // random indices and unknown codes mixed in.
  task automatic test_random_traffic(input int num_requests);
    int                  sel;
    logic [OP_W-1:0]     op;
    logic [SEM_ID_W-1:0] id;
    logic [INIT_W-1:0]   init;
    for (int n = 0; n < num_requests; n++) begin
      sel  = $urandom_range(99);
      id   = SEM_ID_W'($urandom_range(255));
      init = pick_init();
      if (sel < 14) begin
        op = OP_ALLOC;
      end else if (sel < 24) begin
        op = OP_OPEN;
        if ($urandom_range(3) == 0) id = pick_open_id();
      end else if (sel < 34) begin
        op = OP_CLOSE;
        if ($urandom_range(4) != 0) id = pick_open_id();
      end else if (sel < 94) begin
        op = (sel < 64) ? OP_UP : OP_DOWN;
        if ($urandom_range(7) != 0) id = pick_open_id();
      end else begin
        op = OP_W'($urandom_range(7, 5));
      end
      send_request(op, id, init);
    end
  endtask

  // Receiver: random stalls, or a counted hold-off when one is requested.
  always @(posedge clk) begin
    if (hold_go != hold_seen) begin
      hold_seen  <= hold_go;
      hold_left  <= hold_len;
      out_tready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left  <= hold_left - 1;
      out_tready <= 1'b0;
    end else begin
      out_tready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // Checker: compare each accepted result with the oldest prediction.
  always @(posedge clk) begin
    sem_result_t want;
    sem_result_t got;
    if (rst_n && out_tvalid && out_tready) begin
      got.status   = out_tdata[2:0];
      got.alloc_id = out_tdata[10:3];
      got.wake     = out_tdata[11];
      got.count    = out_tdata[27:12];
      if (expected_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result with no request outstanding: tdata %h", out_tdata);
      end else begin
        want = expected_results.pop_front();
        if (got !== want) begin
          mismatches++;
          if (mismatches <= 10)
            $display({"result mismatch: expected status %0d alloc_id %0d wake %0d count %0d,",
                      " got status %0d alloc_id %0d wake %0d count %0d"},
                     want.status, want.alloc_id, want.wake, want.count,
                     got.status, got.alloc_id, got.wake, got.count);
        end
      end
    end
  end

  // Main sequence: reset once, then three idling phases.
  initial begin
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // sender idles lightly, receiver heavily
    send_idle_pct = 17;
    recv_idle_pct = 80;
    test_directed_cases();
    test_random_traffic(400);

    // swap the idling of the two sides
    send_idle_pct = 80;
    recv_idle_pct = 17;
    test_table_exhaustion();
    test_random_traffic(400);

    // no idling; long receiver hold-off first
    send_idle_pct = 0;
    recv_idle_pct = 0;
    test_output_backpressure();
    test_random_traffic(400);

    in_tvalid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    // drain: catch any stray result beyond the last one expected
    repeat (16) @(posedge clk);
    if (mismatches == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest correct run.
  initial begin
    #2000000;
    $display("end of test: mismatches");
    $finish;
  end

endmodule

// ----- filelist.f -----
+incdir+hdl
hdl/csem_pkg.sv
hdl/csem_ram.sv
hdl/csem_free_find.sv
hdl/counting_semaphore_table_unit.sv
tb/counting_semaphore_table_unit_tb.sv
